// ----- hdl/qdec_pkg.sv -----
// Shared types, constants and the phase transition table for the quadrature decoder.
package qdec_pkg;

    localparam int COUNT_BITS = 32;
    localparam int TIME_BITS  = 32;
    localparam int CFG_BITS   = 32;

    localparam logic [CFG_BITS-1:0] MIN_INTERVAL_RST = CFG_BITS'(250000);
    localparam logic [CFG_BITS-1:0] MAX_INTERVAL_RST = CFG_BITS'(500000);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_FWD  = 2'd1,
        MODE_REV  = 2'd2,
        MODE_ERR  = 2'd3
    } t_mode;

    typedef enum logic {
        CFG_MIN_INTERVAL = 1'b0,
        CFG_MAX_INTERVAL = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]           phase;
        logic                 clear_error;
        logic [TIME_BITS-1:0] timestamp;
    } t_qdec_in;

    typedef struct packed {
        logic signed [COUNT_BITS-1:0] position;
        t_mode                        mode;
        logic                         updated;
        logic signed [COUNT_BITS-1:0] step_delta;
    } t_qdec_out;

    typedef struct packed {
        t_mode                 mode;
        logic [1:0]            prev_phase;
        logic                  primed;
        logic [COUNT_BITS-1:0] step_count;
        logic [COUNT_BITS-1:0] count_at_update;
        logic [TIME_BITS-1:0]  last_update_time;
        logic [COUNT_BITS-1:0] held_delta;
    } t_qdec_state;

    // x4 transition table, indexed by previous and current phase
    function automatic t_mode step_class(input logic [1:0] prev, input logic [1:0] cur);
        t_mode m;
        unique case ({prev, cur})
            4'b00_00, 4'b01_01, 4'b10_10, 4'b11_11: m = MODE_IDLE;
            4'b00_10, 4'b01_00, 4'b10_11, 4'b11_01: m = MODE_FWD;
            4'b00_01, 4'b01_11, 4'b10_00, 4'b11_10: m = MODE_REV;
            default:                                 m = MODE_ERR;
        endcase
        return m;
    endfunction

endpackage

// ----- hdl/qdec_step.sv -----
// Per-sample classification, count and delta update for the quadrature decoder.
module qdec_step
    import qdec_pkg::*;
(
    input  t_qdec_state           i_state,
    input  t_qdec_in              i_sample,
    input  logic [TIME_BITS-1:0]  i_min_interval,
    input  logic [TIME_BITS-1:0]  i_max_interval,
    output t_qdec_state           o_state,
    output t_qdec_out             o_result
);

    t_qdec_state          s;
    logic [TIME_BITS-1:0] dt;
    logic                 upd;

    always_comb begin
        s   = i_state;
        dt  = '0;
        upd = 1'b0;

        // first sample after reset seeds the phase and the time base
        if (!s.primed) begin
            s.prev_phase       = i_sample.phase;
            s.last_update_time = i_sample.timestamp;
            s.primed           = 1'b1;
        end

        if (s.mode != MODE_ERR) begin
            s.mode = step_class(s.prev_phase, i_sample.phase);
        end

        // clear while in error: re-base on this sample
        if (s.mode == MODE_ERR && i_sample.clear_error) begin
            s.prev_phase       = i_sample.phase;
            s.last_update_time = i_sample.timestamp;
            s.step_count       = '0;
            s.count_at_update  = '0;
            s.held_delta       = '0;
            s.mode             = MODE_IDLE;
        end

        if (s.mode != MODE_ERR) begin
            case (s.mode)
                MODE_FWD: s.step_count = s.step_count + COUNT_BITS'(1);
                MODE_REV: s.step_count = s.step_count - COUNT_BITS'(1);
                default:  s.step_count = s.step_count;
            endcase

            dt = i_sample.timestamp - s.last_update_time;
            if ((dt >= i_min_interval && i_sample.phase != s.prev_phase)
                    || dt >= i_max_interval) begin
                s.held_delta       = s.step_count - s.count_at_update;
                s.count_at_update  = s.step_count;
                s.last_update_time = i_sample.timestamp;
                upd                = 1'b1;
            end
            s.prev_phase = i_sample.phase;
        end
    end

    assign o_state             = s;
    assign o_result.position   = s.step_count;
    assign o_result.mode       = s.mode;
    assign o_result.updated    = upd;
    assign o_result.step_delta = s.held_delta;

endmodule

// ----- hdl/quadrature_decoder_with_error_latch.sv -----
// Top level of the x4 quadrature decoder with latched error and step delta.
//
//   channel   direction  handshake                payload
//   in        in         i_in_valid / o_in_ready  i_in_data  (phase, clear_error, timestamp)
//   out       out        o_out_valid / i_out_ready o_out_data (position, mode, updated, step_delta)
//   cfg       in         i_cfg_we (no wait)       i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the output is not stalled. An accepted item
// is held in the input register, then the single pass of table lookup, increment
// and interval compare fills the result register.
// Reset (synchronous, active low) empties both registers, zeroes the counts and
// loads the interval defaults. A stalled result holds the result register; the
// input register still takes one more item behind it, then ready drops.
module quadrature_decoder_with_error_latch
    import qdec_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_qdec_in            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_qdec_out           o_out_data,
    input  logic                i_cfg_we,
    input  t_cfg_idx            i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    logic                 r_in_valid;
    t_qdec_in             r_in;
    logic                 r_out_valid;
    t_qdec_out            r_out;
    t_qdec_state          r_state;
    logic [TIME_BITS-1:0] r_min_interval;
    logic [TIME_BITS-1:0] r_max_interval;

    t_qdec_state          n_state;
    t_qdec_out            n_out;
    logic                 w_fire;
    logic                 w_accept;

    // advance the input register into the result register when the latter is free
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;
    assign w_accept   = i_in_valid && o_in_ready;

    qdec_step u_step (
        .i_state        (r_state),
        .i_sample       (r_in),
        .i_min_interval (r_min_interval),
        .i_max_interval (r_max_interval),
        .o_state        (n_state),
        .o_result       (n_out)
    );

    // handshake and decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid             <= 1'b0;
            r_out_valid            <= 1'b0;
            r_state.mode           <= MODE_IDLE;
            r_state.prev_phase     <= '0;
            r_state.primed         <= 1'b0;
            r_state.step_count     <= '0;
            r_state.count_at_update <= '0;
            r_state.last_update_time <= '0;
            r_state.held_delta     <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    // interval registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= MIN_INTERVAL_RST;
            r_max_interval <= MAX_INTERVAL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_INTERVAL: r_min_interval <= i_cfg_data;
                CFG_MAX_INTERVAL: r_max_interval <= i_cfg_data;
                default:          r_min_interval <= r_min_interval;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // error latches until a clear arrives
    a_err_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_state.mode == MODE_ERR && !r_in.clear_error)
            |=> r_state.mode == MODE_ERR)
        else $error("error mode dropped without clear");

    // an item reported in error never carries a delta update
    a_err_no_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.mode == MODE_ERR) |-> !o_out_data.updated)
        else $error("update reported in error mode");

    // once primed, the decoder stays primed until reset
    a_primed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.primed |=> r_state.primed)
        else $error("primed flag lost");

endmodule
